/* design/k_nearest_candidate_list_assert.svh */
// Assertion macros used by the candidate list drain sequencer
`ifndef K_NEAREST_CANDIDATE_LIST_ASSERT_SVH
`define K_NEAREST_CANDIDATE_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define KNCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that one condition is followed by another on the next edge
`define KNCL_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define KNCL_ASSERT(lbl, prop, msg)
`define KNCL_ASSERT_NEXT(lbl, cause, effect, msg)
`endif
`endif

/* design/kncl_pkg.sv */
// Types, constants and helpers of the K nearest candidate list
package kncl_pkg;

  localparam int MAX_CANDIDATES = 32;
  localparam int NODE_BITS      = 16;
  localparam int DIST_W         = 32;
  localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CAND_CNT_RESET = 8;

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_CAND_COUNT = 1'b0,
    REG_ROW_NODE   = 1'b1
  } reg_idx_t;

  // One list slot as handed between neighbouring cells
  typedef struct packed {
    logic  valid;
    node_t node;
    dist_t distance;
  } slot_t;

  localparam slot_t EMPTY_SLOT = '{valid: 1'b0, node: '0, distance: '1};

  // Per-cycle operation applied to every cell
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_op_t;

  // Drain sequencer status towards the top level
  typedef struct packed {
    logic busy;
    logic shift;
    logic clr;
  } drain_ctl_t;

  // Cut or extend a 16-bit node field to the internal node width
  function automatic node_t to_node(input logic [15:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[NODE_BITS-1:0];
  endfunction

  // Cut or extend an internal node to the 16-bit result field
  function automatic logic [15:0] from_node(input node_t n);
    logic [63:0] t;
    t = 64'(n);
    return t[15:0];
  endfunction

endpackage

/* design/kncl_cell.sv */
// One slot of the sorted candidate chain
module kncl_cell
  import kncl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cell_op_t op,
  input  node_t    new_node,
  input  dist_t    new_dist,
  input  logic     c_prev,
  input  slot_t    prev_slot,
  input  slot_t    next_slot,
  output slot_t    slot,
  output logic     c_here
);

  logic  valid_r;
  node_t node_r;
  dist_t dist_r;

  // New entry belongs at or above this slot
  assign c_here = !valid_r || (new_dist < dist_r);

  assign slot = '{valid: valid_r, node: node_r, distance: dist_r};

  // Hold valid bit: clear, take from above or set on insert, take from below on drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      priority if (op.clr) begin
        valid_r <= 1'b0;
      end else if (op.ins) begin
        if (c_prev) begin
          valid_r <= prev_slot.valid;
        end else if (c_here) begin
          valid_r <= 1'b1;
        end
      end else if (op.shift) begin
        valid_r <= next_slot.valid;
      end
    end
  end

  // Move payload alongside the valid bit
  always_ff @(posedge clk) begin
    if (op.ins && !op.clr) begin
      if (c_prev) begin
        node_r <= prev_slot.node;
        dist_r <= prev_slot.distance;
      end else if (c_here) begin
        node_r <= new_node;
        dist_r <= new_dist;
      end
    end else if (op.shift && !op.clr) begin
      node_r <= next_slot.node;
      dist_r <= next_slot.distance;
    end
  end

endmodule

/* design/kncl_drain.sv */
// Drain sequencer and result register of the candidate list
module kncl_drain
  import kncl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  idx_t        k_last,
  input  slot_t       head,
  output drain_ctl_t  ctl,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cand_node,
  output dist_t       out_cand_distance,
  output logic        out_list_end
);

  `include "k_nearest_candidate_list_assert.svh"

  typedef enum logic {ST_FILL, ST_DRAIN} state_t;

  state_t      state_r;
  idx_t        cnt_r;
  idx_t        k_last_r;
  logic        out_valid_r;
  logic [15:0] out_node_r;
  dist_t       out_dist_r;
  logic        out_end_r;
  logic        load;
  logic        last;

  // Load the result register whenever it is free during a drain
  assign load = (state_r == ST_DRAIN) && (!out_valid_r || !out_stall);
  assign last = (cnt_r == k_last_r);

  assign ctl.busy  = (state_r == ST_DRAIN);
  assign ctl.shift = load && !last;
  assign ctl.clr   = load && last;

  // Hold state, count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      k_last_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_node_r  <= head.valid ? from_node(head.node) : 16'd0;
        out_dist_r  <= head.valid ? head.distance : '1;
        out_end_r   <= last;
        cnt_r       <= last ? '0 : cnt_r + idx_t'(1);
        if (last) begin
          state_r <= ST_FILL;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (start) begin
        state_r  <= ST_DRAIN;
        k_last_r <= k_last;
        cnt_r    <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cand_node     = out_node_r;
  assign out_cand_distance = out_dist_r;
  assign out_list_end      = out_end_r;

  `KNCL_ASSERT(a_start_when_filling, start |-> (state_r == ST_FILL), "row end taken during drain")
  `KNCL_ASSERT(a_cnt_in_range, (state_r == ST_DRAIN) |-> (cnt_r <= k_last_r), "drain count overrun")
  `KNCL_ASSERT_NEXT(a_clr_ends_row, ctl.clr, out_valid_r && out_end_r && (state_r == ST_FILL), "last transaction not marked")

endmodule

/* design/k_nearest_candidate_list.sv */
// Top level: K nearest candidate list built as a chain of sorting cells
// Accepts one item per cycle while filling; an item is inserted in the same cycle.
// On an item with row_end, the drain begins and the first result is registered from the
// head slot; K results (K = cand_count clamped to 1..MAX_CANDIDATES) follow at one per
// cycle while out_stall is low, as the cell chain shifts out; input stalls meanwhile.
// Reset empties every slot at once and sets cand_count to 8, row_node to 0.
module k_nearest_candidate_list
  import kncl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_node_id,
  input  logic [31:0] in_distance,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cand_node,
  output logic [31:0] out_cand_distance,
  output logic        out_list_end,
  input  logic        cfg_wr_en,
  input  reg_idx_t    cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [5:0]  cand_count_r;
  logic [15:0] row_node_r;
  logic        in_accept;
  logic        skip;
  idx_t        k_last;
  logic [6:0]  cnt_ext;
  cell_op_t    op;
  drain_ctl_t  dctl;
  node_t       new_node;
  slot_t       slots [MAX_CANDIDATES];
  logic        c_flag [MAX_CANDIDATES];

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_count_r <= 6'(CAND_CNT_RESET);
      row_node_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAND_COUNT: cand_count_r <= cfg_wdata[5:0];
        REG_ROW_NODE:   row_node_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Clamp the candidate count and keep its last index
  assign cnt_ext = 7'(cand_count_r);
  always_comb begin
    if (cnt_ext == 7'd0) begin
      k_last = '0;
    end else if (cnt_ext > 7'(MAX_CANDIDATES)) begin
      k_last = idx_t'(MAX_CANDIDATES - 1);
    end else begin
      k_last = idx_t'(cnt_ext - 7'd1);
    end
  end

  // Accept items while not draining; drop the row's own node
  assign in_stall  = dctl.busy;
  assign in_accept = in_valid && !in_stall;
  assign new_node  = to_node(in_node_id);
  assign skip      = (new_node == to_node(row_node_r));

  assign op.ins   = in_accept && !skip;
  assign op.shift = dctl.shift;
  assign op.clr   = dctl.clr;

  // Chain of slot cells
  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
    slot_t prev_s;
    slot_t next_s;
    logic  c_up;
    if (i == 0) begin : g_head
      assign prev_s = EMPTY_SLOT;
      assign c_up   = 1'b0;
    end else begin : g_body
      assign prev_s = slots[i-1];
      assign c_up   = c_flag[i-1];
    end
    if (i == MAX_CANDIDATES - 1) begin : g_tail
      assign next_s = EMPTY_SLOT;
    end else begin : g_mid
      assign next_s = slots[i+1];
    end
    kncl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .new_node  (new_node),
      .new_dist  (in_distance),
      .c_prev    (c_up),
      .prev_slot (prev_s),
      .next_slot (next_s),
      .slot      (slots[i]),
      .c_here    (c_flag[i])
    );
  end

  // Shift the list out after the row's last transaction
  kncl_drain u_drain (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (in_accept && in_row_end),
    .k_last            (k_last),
    .head              (slots[0]),
    .ctl               (dctl),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cand_node     (out_cand_node),
    .out_cand_distance (out_cand_distance),
    .out_list_end      (out_list_end)
  );

endmodule

/* verif/k_nearest_candidate_list_tb.sv */
// Testbench of the K nearest candidate list: directed and random rows checked against a predictor
`timescale 1ns / 100ps
module k_nearest_candidate_list_tb;
  import kncl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = MAX_CANDIDATES + 8;
  localparam logic [15:0] NODE_ALL_ONES = 16'hFFFF;
  localparam dist_t       DIST_ALL_ONES = 32'hFFFF_FFFF;

  // One emitted candidate as seen on the result channel
  typedef struct packed {
    logic [15:0] node;
    dist_t       distance;
    logic        list_end;
  } cand_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_node_id;
  logic [31:0] in_distance;
  logic        in_row_end;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_cand_node;
  logic [31:0] out_cand_distance;
  logic        out_list_end;
  logic        cfg_wr_en;
  reg_idx_t    cfg_index;
  logic [15:0] cfg_wdata;

  int          err_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_len;

  // Predicted list contents and register copies
  node_t        model_node [MAX_CANDIDATES];
  dist_t        model_dist [MAX_CANDIDATES];
  logic         model_used [MAX_CANDIDATES];
  logic [5:0]   model_cand_count;
  logic [15:0]  model_row_node;
  cand_result_t pending_cands[$];

  k_nearest_candidate_list u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_node_id        (in_node_id),
    .in_distance       (in_distance),
    .in_row_end        (in_row_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cand_node     (out_cand_node),
    .out_cand_distance (out_cand_distance),
    .out_list_end      (out_list_end),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if the results never arrive
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** k_nearest_candidate_list: FAILED **");
    $finish;
  end

  // Empty every slot of the predicted list
  function automatic void clear_model_list();
    for (int m = 0; m < MAX_CANDIDATES; m++) begin
      model_node[m] = '0;
      model_dist[m] = DIST_ALL_ONES;
      model_used[m] = 1'b0;
    end
  endfunction

  // Insert one accepted transaction and queue the row's candidates on row end
  function automatic void predict_candidates(input node_t node, input dist_t distance,
                                             input logic row_end);
    int pos;
    int k;
    pos = -1;
    if (node != node_t'(model_row_node)) begin
      for (int m = 0; m < MAX_CANDIDATES; m++) begin
        if (pos < 0 && (!model_used[m] || distance < model_dist[m])) pos = m;
      end
      if (pos >= 0) begin
        for (int m = MAX_CANDIDATES - 1; m > pos; m--) begin
          model_node[m] = model_node[m-1];
          model_dist[m] = model_dist[m-1];
          model_used[m] = model_used[m-1];
        end
        model_node[pos] = node;
        model_dist[pos] = distance;
        model_used[pos] = 1'b1;
      end
    end
    if (row_end) begin
      // A count of zero gives one candidate, anything above the depth saturates
      k = int'(model_cand_count);
      if (k < 1) k = 1;
      if (k > MAX_CANDIDATES) k = MAX_CANDIDATES;
      for (int t = 0; t < k; t++) begin
        pending_cands.push_back('{node:     model_used[t] ? 16'(model_node[t]) : 16'h0000,
                                  distance: model_used[t] ? model_dist[t] : DIST_ALL_ONES,
                                  list_end: (t == k - 1)});
      end
      clear_model_list();
    end
  endfunction

  // Offer one transaction, hold it until accepted, then predict its results
  task automatic send_item(input node_t node, input dist_t distance, input logic row_end);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid    = 1'b1;
    in_node_id  = node;
    in_distance = distance;
    in_row_end  = row_end;
    do @(posedge clk); while (in_stall);
    predict_candidates(node, distance, row_end);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Write a register once every expected candidate has drained
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    while (pending_cands.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_CAND_COUNT: model_cand_count = val[5:0];
      REG_ROW_NODE:   model_row_node   = val;
      default:        ;
    endcase
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int unsigned held;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        held         = hold_off_len;
        hold_off_len = 0;
      end
      if (held > 0) begin
        out_stall = 1'b1;
        held--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare every accepted candidate with the oldest prediction
  always @(posedge clk) begin : check_results
    cand_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cands.size() == 0) begin
        $error("unexpected candidate: cand_node %0d cand_distance %0d list_end %0b",
               out_cand_node, out_cand_distance, out_list_end);
        err_count++;
      end else begin
        want = pending_cands.pop_front();
        if (out_cand_node !== want.node) begin
          $error("cand_node: expected %0d, actual %0d", want.node, out_cand_node);
          err_count++;
        end
        if (out_cand_distance !== want.distance) begin
          $error("cand_distance: expected %0d, actual %0d", want.distance, out_cand_distance);
          err_count++;
        end
        if (out_list_end !== want.list_end) begin
          $error("list_end: expected %0b, actual %0b", want.list_end, out_list_end);
          err_count++;
        end
      end
    end
  end

  // Reset values: eight candidates, node zero skipped
  task automatic test_reset_defaults();
    send_item(16'd9, 32'd3, 1'b0);
    send_item(16'd0, 32'd5, 1'b1);
  endtask

  // Field extremes, ties, count clamping and skipped row ends
  task automatic test_directed_cases();
    write_reg(REG_CAND_COUNT, 16'd4);
    write_reg(REG_ROW_NODE, NODE_ALL_ONES);
    send_item(NODE_ALL_ONES, 32'd0, 1'b0);
    send_item(16'd1, DIST_ALL_ONES, 1'b0);
    send_item(16'd2, 32'd100, 1'b0);
    send_item(16'd3, 32'd100, 1'b0);
    send_item(16'd4, 32'd0, 1'b0);
    send_item(16'h8000, 32'd50, 1'b0);
    send_item(16'd5, 32'd100, 1'b1);
    write_reg(REG_CAND_COUNT, 16'd0);
    send_item(16'd10, 32'd20, 1'b0);
    send_item(16'd11, 32'd7, 1'b1);
    write_reg(REG_CAND_COUNT, 16'd63);
    send_item(16'hAAAA, 32'h5555_5555, 1'b0);
    send_item(16'h5555, 32'hAAAA_AAAA, 1'b1);
    write_reg(REG_CAND_COUNT, 16'd32);
    write_reg(REG_ROW_NODE, 16'h1234);
    send_item(16'h1234, 32'd1, 1'b1);
    write_reg(REG_CAND_COUNT, 16'd1);
    send_item(16'd7, 32'd9, 1'b0);
    send_item(16'd8, 32'd9, 1'b1);
  endtask

  // Random rows with random settings between them; some overflow the list
  task automatic test_random_rows(input int unsigned n_items);
    int unsigned sent;
    int unsigned row_len;
    int unsigned pick;
    node_t       node;
    dist_t       distance;
    logic        row_end;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(9);
        case (pick)
          6:       write_reg(REG_CAND_COUNT, 16'd0);
          7:       write_reg(REG_CAND_COUNT, 16'd63);
          8:       write_reg(REG_CAND_COUNT, 16'd32);
          9:       write_reg(REG_CAND_COUNT, 16'($urandom_range(31, 9)));
          default: write_reg(REG_CAND_COUNT, 16'($urandom_range(8, 1)));
        endcase
      end
      if ($urandom_range(4) == 0) begin
        pick = $urandom_range(3);
        case (pick)
          0:       write_reg(REG_ROW_NODE, 16'h0000);
          1:       write_reg(REG_ROW_NODE, NODE_ALL_ONES);
          default: write_reg(REG_ROW_NODE, 16'($urandom));
        endcase
      end
      row_len = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
      for (int unsigned i = 0; i < row_len; i++) begin
        node = ($urandom_range(15) < 2) ? node_t'(model_row_node) : node_t'($urandom);
        // Bias towards ties and the distance extremes
        pick = $urandom_range(15);
        case (pick)
          0, 1, 2, 3: distance = dist_t'($urandom_range(3));
          4:          distance = '0;
          5:          distance = DIST_ALL_ONES;
          default:    distance = dist_t'($urandom);
        endcase
        // Now and then end the row early
        row_end = (i == row_len - 1) || ($urandom_range(29) == 0);
        send_item(node, distance, row_end);
      end
      sent += row_len;
    end
  endtask

  // Hold the receiver off while rows keep coming, so the input stalls
  task automatic test_stall_pressure();
    write_reg(REG_CAND_COUNT, 16'd32);
    hold_off_len = 300;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 8; i++) begin
        send_item(node_t'($urandom), dist_t'($urandom), (i == 7));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_node_id    = '0;
    in_distance   = '0;
    in_row_end    = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_CAND_COUNT;
    cfg_wdata     = '0;
    err_count     = 0;
    hold_off_len  = 0;
    send_idle_pct = 10;
    recv_idle_pct = 78;
    model_cand_count = 6'(CAND_CNT_RESET);
    model_row_node   = '0;
    clear_model_list();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_directed_cases();
    test_random_rows(150);

    send_idle_pct = 78;
    recv_idle_pct = 10;
    test_random_rows(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_stall_pressure();
    test_random_rows(130);

    // Drain, then allow the block's own latency
    while (pending_cands.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("** k_nearest_candidate_list: PASSED **");
    end else begin
      $display("** k_nearest_candidate_list: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/kncl_pkg.sv
design/kncl_cell.sv
design/kncl_drain.sv
design/k_nearest_candidate_list.sv
verif/k_nearest_candidate_list_tb.sv
